>>> rtl/qpc_pkg.sv
// Shared types, codes and constants for the quadrature position counter.
`timescale 1ns / 1ps
`default_nettype none

package qpc_pkg;

    // Field widths
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned PPT_W   = 15;
    localparam int unsigned LINES_W = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = PPT_W;

    // Line state codes, bit1 = A, bit0 = B
    localparam logic [LINES_W-1:0] LINES_NONE = 2'h0;
    localparam logic [LINES_W-1:0] LINE_B_BIT = 2'h1;
    localparam logic [LINES_W-1:0] LINE_A_BIT = 2'h2;
    localparam logic [LINES_W-1:0] LINES_BOTH = 2'h3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_MODE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_TURN = 1'b1;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } op_t;

    typedef enum logic {
        MODE_X2 = 1'b0,
        MODE_X4 = 1'b1
    } mode_t;

    // Count step decoded from one pair of line states
    typedef struct packed {
        logic up;
        logic down;
    } step_t;

endpackage : qpc_pkg

`default_nettype wire

>>> rtl/quadrature_position_counter.sv
// Quadrature position counter: input register, count update and result register.
//
// Usage: each input word carries an operation (sample or clear) and the sampled
// levels of channels A and B. Every accepted word yields exactly one result word
// with the pulse count, the revolution count and the line state after that word.
// Both channels use valid/ready; a word is taken when valid and ready are high.
// Order: an accepted word enters the input register, and its count update moves
// into the result register once that register is empty or being drained, from
// where the result word is offered to the receiver.
// Throughput: one word per cycle unless the receiver stalls, set by the
// combinational update (step, add, fold compare and add) between the registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more word; ready drops only once both are full.
// Configuration (count_mode, pulses_per_turn) is written through cfg_write_en,
// cfg_index and cfg_data, by the user only while idle, which the block does not
// enforce; it takes effect at once. Reset clears counts, line history and both
// valid flags and sets X4 mode, no folding; the first sample only records lines.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_position_counter
    import qpc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_write_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    // input words
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      operation,
    input  logic                      chan_a,
    input  logic                      chan_b,
    // result words
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COUNT_W-1:0] pulse_count,
    output logic signed [COUNT_W-1:0] revolution_count,
    output logic [LINES_W-1:0]        line_state
);

    // Configuration registers
    mode_t              count_mode_reg;
    logic [PPT_W-1:0]   ppt_reg;

    // Input register
    logic               in_valid_reg;
    op_t                in_op_reg;
    logic [LINES_W-1:0] in_lines_reg;

    // Counter state
    logic [LINES_W-1:0] last_lines_reg, last_lines_next;
    logic               primed_reg, primed_next;
    logic signed [COUNT_W-1:0] pulse_total_reg, pulse_total_next;
    logic signed [COUNT_W-1:0] turn_total_reg, turn_total_next;

    // Result register
    logic               out_valid_reg;
    logic signed [COUNT_W-1:0] pulse_out_reg;
    logic signed [COUNT_W-1:0] turn_out_reg;
    logic [LINES_W-1:0] lines_out_reg;
    logic [LINES_W-1:0] shown_next;

    logic               advance;
    step_t              step;
    logic signed [COUNT_W-1:0] stepped;
    logic signed [COUNT_W-1:0] ppt_ext;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_mode_reg <= MODE_X4;
            ppt_reg        <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_COUNT_MODE:      count_mode_reg <= mode_t'(cfg_data[0]);
                REG_PULSES_PER_TURN: ppt_reg        <= cfg_data[PPT_W-1:0];
                default:             ppt_reg        <= ppt_reg;
            endcase
        end
    end

    // Capture an input word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_op_reg    <= op_t'(operation);
            in_lines_reg <= {chan_a, chan_b};
        end
    end

    qpc_step_decode u_step_decode (
        .mode       (count_mode_reg),
        .prev_lines (last_lines_reg),
        .curr_lines (in_lines_reg),
        .step       (step)
    );

    assign ppt_ext = signed'({{(COUNT_W-PPT_W){1'b0}}, ppt_reg});

    // Clear or prime, else step the pulse count and fold one revolution on overrun
    always_comb
    begin
        last_lines_next  = last_lines_reg;
        primed_next      = primed_reg;
        pulse_total_next = pulse_total_reg;
        turn_total_next  = turn_total_reg;
        shown_next       = last_lines_reg;
        stepped          = pulse_total_reg;

        priority if (in_op_reg == OP_CLEAR)
        begin
            pulse_total_next = '0;
            turn_total_next  = '0;
        end
        else if (!primed_reg)
        begin
            last_lines_next = in_lines_reg;
            primed_next     = 1'b1;
            shown_next      = in_lines_reg;
        end
        else
        begin
            priority if (step.up)
                stepped = pulse_total_reg + COUNT_W'(1);
            else if (step.down)
                stepped = pulse_total_reg - COUNT_W'(1);
            else
                stepped = pulse_total_reg;

            pulse_total_next = stepped;
            if (ppt_reg != '0)
            begin
                priority if (stepped >= ppt_ext)
                begin
                    turn_total_next  = turn_total_reg + COUNT_W'(1);
                    pulse_total_next = stepped - ppt_ext;
                end
                else if (stepped <= -ppt_ext)
                begin
                    turn_total_next  = turn_total_reg - COUNT_W'(1);
                    pulse_total_next = stepped + ppt_ext;
                end
                else
                begin
                    pulse_total_next = stepped;
                end
            end
            last_lines_next = in_lines_reg;
            shown_next      = in_lines_reg;
        end
    end

    // Advance counter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_lines_reg  <= LINES_NONE;
            primed_reg      <= 1'b0;
            pulse_total_reg <= '0;
            turn_total_reg  <= '0;
        end
        else if (advance)
        begin
            last_lines_reg  <= last_lines_next;
            primed_reg      <= primed_next;
            pulse_total_reg <= pulse_total_next;
            turn_total_reg  <= turn_total_next;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pulse_out_reg <= pulse_total_next;
            turn_out_reg  <= turn_total_next;
            lines_out_reg <= shown_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign pulse_count      = pulse_out_reg;
    assign revolution_count = turn_out_reg;
    assign line_state       = lines_out_reg;

    // A clear leaves both counts at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_op_reg == OP_CLEAR) |=>
            (pulse_total_reg == '0) && (turn_total_reg == '0))
        else $error("counts not zero after clear");

    // The priming sample counts nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_op_reg == OP_SAMPLE) && !primed_reg |=>
            $stable(pulse_total_reg) && $stable(turn_total_reg) && primed_reg)
        else $error("priming sample changed the counts");

    // A sample moves the revolution count by at most one
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_op_reg == OP_SAMPLE) |=>
            (turn_total_reg == $past(turn_total_reg))
            || (turn_total_reg == $past(turn_total_reg) + COUNT_W'(1))
            || (turn_total_reg == $past(turn_total_reg) - COUNT_W'(1)))
        else $error("revolution count jumped");

    // Ready drops only with both registers full and the output stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without cause");

    // The result register is loaded only while empty or being drained
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(pulse_out_reg) && $stable(turn_out_reg))
        else $error("result overwritten while stalled");

endmodule : quadrature_position_counter

`default_nettype wire

>>> rtl/qpc_step_decode.sv
// Transition decoder: turns previous and current line states into a count step.
`timescale 1ns / 1ps
`default_nettype none

module qpc_step_decode
    import qpc_pkg::*;
(
    input  mode_t              mode,
    input  logic [LINES_W-1:0] prev_lines,
    input  logic [LINES_W-1:0] curr_lines,
    output step_t              step
);

    logic [LINES_W-1:0] diff;
    logic               single_change;
    logic               x4_down;

    assign diff          = prev_lines ^ curr_lines;
    assign single_change = (diff == LINE_A_BIT) || (diff == LINE_B_BIT);
    // previous B xor current A gives the direction; one means down
    assign x4_down       = prev_lines[0] ^ curr_lines[1];

    // Pick the step according to the counting mode
    always_comb
    begin
        step = '0;
        unique case (mode)
            MODE_X2:
            begin
                step.up   = ((prev_lines == LINES_BOTH) && (curr_lines == LINES_NONE))
                         || ((prev_lines == LINES_NONE) && (curr_lines == LINES_BOTH));
                step.down = ((prev_lines == LINE_A_BIT) && (curr_lines == LINE_B_BIT))
                         || ((prev_lines == LINE_B_BIT) && (curr_lines == LINE_A_BIT));
            end
            MODE_X4:
            begin
                step.up   = single_change && !x4_down;
                step.down = single_change && x4_down;
            end
            default:
            begin
                step = '0;
            end
        endcase
    end

endmodule : qpc_step_decode

`default_nettype wire

>>> tb/tb_quadrature_position_counter.sv
// Self-checking testbench for the quadrature position counter: encoder walks, clears, folding.
`timescale 1ns / 1ps

module tb_quadrature_position_counter;
    import qpc_pkg::*;

    typedef struct {
        op_t                op;
        logic [LINES_W-1:0] lines;
    } enc_word_t;

    typedef struct {
        logic signed [COUNT_W-1:0] pulses;
        logic signed [COUNT_W-1:0] turns;
        logic [LINES_W-1:0]        lines;
    } count_word_t;

    localparam int N_SEGMENTS   = 6;
    localparam int WALK_WORDS   = 205;
    localparam int DRAIN_CYCLES = 6;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index    = REG_COUNT_MODE;
    logic [CFG_DATA_W-1:0]     cfg_data     = '0;
    logic                      in_valid     = 1'b0;
    logic                      in_ready;
    logic                      operation    = OP_SAMPLE;
    logic                      chan_a       = 1'b0;
    logic                      chan_b       = 1'b0;
    logic                      out_valid;
    logic                      out_ready    = 1'b0;
    logic signed [COUNT_W-1:0] pulse_count;
    logic signed [COUNT_W-1:0] revolution_count;
    logic [LINES_W-1:0]        line_state;

    // Decoder state as the testbench expects it
    mode_t                     enc_mode       = MODE_X4;
    logic [PPT_W-1:0]          enc_ppt        = '0;
    logic [LINES_W-1:0]        enc_last_lines = LINES_NONE;
    logic                      enc_primed     = 1'b0;
    logic signed [COUNT_W-1:0] enc_pulses     = '0;
    logic signed [COUNT_W-1:0] enc_turns      = '0;

    enc_word_t   words_to_send[$];
    count_word_t counts_due[$];

    logic               word_taken        = 1'b0;
    logic [LINES_W-1:0] walk_lines        = LINES_NONE;
    logic               walk_up           = 1'b1;
    int                 sender_idle_pct   = 0;
    int                 receiver_idle_pct = 0;
    int                 error_count       = 0;
    int                 words_sent        = 0;
    int                 clears_sent       = 0;
    int                 results_seen      = 0;
    int                 folds_seen        = 0;

    quadrature_position_counter u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .chan_a           (chan_a),
        .chan_b           (chan_b),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .pulse_count      (pulse_count),
        .revolution_count (revolution_count),
        .line_state       (line_state)
    );

    always #5 clk = ~clk;

    // Work out the counts that follow one accepted word
    task automatic decode_word(input op_t op, input logic [LINES_W-1:0] now_lines);
        logic [LINES_W-1:0] moved;
        int                 span;
        count_word_t        res;
        span  = int'(enc_ppt);
        moved = enc_last_lines ^ now_lines;
        words_sent++;
        if (op == OP_CLEAR) begin
            enc_pulses = '0;
            enc_turns  = '0;
            res.lines  = enc_last_lines;
            clears_sent++;
        end
        else if (!enc_primed) begin
            // first sample only records the lines
            enc_last_lines = now_lines;
            enc_primed     = 1'b1;
            res.lines      = now_lines;
        end
        else begin
            if (enc_mode == MODE_X2) begin
                // diagonal jumps only: through none/both counts up, through A/B down
                if (moved == LINES_BOTH && (now_lines == LINES_NONE || now_lines == LINES_BOTH))
                    enc_pulses += 1;
                else if (moved == LINES_BOTH)
                    enc_pulses -= 1;
            end
            else if (moved == LINE_A_BIT || moved == LINE_B_BIT) begin
                if (enc_last_lines[0] ^ now_lines[1])
                    enc_pulses -= 1;
                else
                    enc_pulses += 1;
            end
            // fold at most one revolution per sample
            if (span != 0) begin
                if (enc_pulses >= span) begin
                    enc_turns  += 1;
                    enc_pulses -= span;
                    folds_seen++;
                end
                else if (enc_pulses <= -span) begin
                    enc_turns  -= 1;
                    enc_pulses += span;
                    folds_seen++;
                end
            end
            enc_last_lines = now_lines;
            res.lines      = now_lines;
        end
        res.pulses = enc_pulses;
        res.turns  = enc_turns;
        counts_due.push_back(res);
    endtask

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Next line state one quarter step along the walk
    function automatic logic [LINES_W-1:0] quad_step(input logic [LINES_W-1:0] lines,
                                                     input logic up);
        case (lines)
            LINES_NONE: return up ? LINE_B_BIT : LINE_A_BIT;
            LINE_B_BIT: return up ? LINES_BOTH : LINES_NONE;
            LINES_BOTH: return up ? LINE_A_BIT : LINE_B_BIT;
            default:    return up ? LINES_NONE : LINES_BOTH;
        endcase
    endfunction

    task automatic queue_sample(input logic [LINES_W-1:0] lines);
        words_to_send.push_back('{op: OP_SAMPLE, lines: lines});
        walk_lines = lines;
    endtask

    task automatic queue_clear();
        words_to_send.push_back('{op: OP_CLEAR, lines: LINES_W'($urandom)});
    endtask

    // Mostly a clean encoder walk with runs, plus holds, jumps, noise and clears
    task automatic queue_walk(input int count, input int diag_pct);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 3)
                queue_clear();
            else if (r < 6)
                queue_sample(LINES_W'($urandom));
            else if (r < 10)
                queue_sample(walk_lines);
            else if (r < 10 + diag_pct)
                queue_sample(walk_lines ^ LINES_BOTH);
            else begin
                if ($urandom_range(15) == 0)
                    walk_up = !walk_up;
                queue_sample(quad_step(walk_lines, walk_up));
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        if (idx == REG_COUNT_MODE)
            enc_mode = mode_t'(value[0]);
        else
            enc_ppt = value;
    endtask

    task automatic wait_drained();
        while (words_to_send.size() != 0 || in_valid || counts_due.size() != 0)
            @(negedge clk);
    endtask

    // Offer the next word once the previous one has gone, idling at random
    always @(negedge clk) begin : drive_words
        enc_word_t w;
        if (rst_n && (!in_valid || word_taken)) begin
            if (words_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                w = words_to_send.pop_front();
                in_valid  <= 1'b1;
                operation <= w.op;
                chan_a    <= w.lines[1];
                chan_b    <= w.lines[0];
            end
            else begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Check result words against the oldest expectation, then record new input words
    always @(posedge clk) begin : check_results
        count_word_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (counts_due.size() == 0) begin
                    flag_error($sformatf("unexpected result word: pulses %0d turns %0d lines %0d",
                                         pulse_count, revolution_count, line_state));
                end
                else begin
                    want = counts_due.pop_front();
                    if (pulse_count !== want.pulses)
                        flag_error($sformatf("pulse_count expected %0d got %0d",
                                             want.pulses, pulse_count));
                    if (revolution_count !== want.turns)
                        flag_error($sformatf("revolution_count expected %0d got %0d",
                                             want.turns, revolution_count));
                    if (line_state !== want.lines)
                        flag_error($sformatf("line_state expected %0d got %0d",
                                             want.lines, line_state));
                end
            end
            if (in_valid && in_ready) begin
                decode_word(op_t'(operation), {chan_a, chan_b});
                word_taken <= 1'b1;
            end
            else begin
                word_taken <= 1'b0;
            end
        end
    end

    initial begin : run_stimulus
        mode_t seg_mode [N_SEGMENTS] = '{MODE_X4, MODE_X2, MODE_X4, MODE_X2, MODE_X4, MODE_X2};
        int    seg_ppt  [N_SEGMENTS] = '{0, 1, 5, 32767, 3, 2};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int s = 0; s < N_SEGMENTS; s++) begin
            // first segment runs on the reset settings
            if (s != 0) begin
                write_reg(REG_COUNT_MODE, CFG_DATA_W'(seg_mode[s]));
                write_reg(REG_PULSES_PER_TURN, CFG_DATA_W'(seg_ppt[s]));
            end
            sender_idle_pct   = (s < 2) ? 26 : (s < 4) ? 69 : 0;
            receiver_idle_pct = (s < 2) ? 69 : (s < 4) ? 26 : 0;
            @(posedge clk);
            if (s == 0) begin
                // clear before any sample, priming, a full turn each way, jumps
                queue_clear();
                queue_sample(LINES_BOTH);
                queue_sample(LINES_BOTH);
                queue_sample(LINE_A_BIT);
                queue_sample(LINES_NONE);
                queue_sample(LINE_B_BIT);
                queue_sample(LINES_BOTH);
                queue_sample(LINE_B_BIT);
                queue_sample(LINES_NONE);
                queue_sample(LINE_A_BIT);
                queue_sample(LINES_BOTH);
                queue_sample(LINES_NONE);
                queue_sample(LINES_BOTH);
                queue_clear();
                queue_sample(LINE_A_BIT);
            end
            else if (s == 1) begin
                // diagonal counting both ways, with a fold on every count
                queue_sample(LINE_B_BIT);
                queue_sample(LINE_A_BIT);
                queue_sample(LINES_NONE);
                queue_sample(LINES_BOTH);
                queue_sample(LINES_NONE);
                queue_sample(LINE_B_BIT);
                queue_sample(LINE_B_BIT);
                queue_clear();
            end
            queue_walk(WALK_WORDS, (seg_mode[s] == MODE_X2) ? 40 : 4);
            wait_drained();
            repeat (DRAIN_CYCLES) @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d words (%0d clears) over %0d register settings in X2 and X4 modes.",
                 words_sent, clears_sent, N_SEGMENTS);
        $display("Checked %0d result words, %0d revolution folds, %0d mismatches.",
                 results_seen, folds_seen, error_count);
        if (error_count == 0 && counts_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("Timed out with %0d result words outstanding", counts_due.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> quadrature_position_counter.f
rtl/qpc_pkg.sv
rtl/qpc_step_decode.sv
rtl/quadrature_position_counter.sv
tb/tb_quadrature_position_counter.sv
